[rtl/core/dri_pkg.sv]
// dri_pkg: shared constants, field widths and the result word type
// for the dna region / trimer indexer core
// no dependencies
package dri_pkg;

    localparam int CNT_W        = 32;
    localparam int POS_BITS_DEF = 32;
    localparam int CHAR_W       = 8;
    localparam int CODE_W       = 3;
    localparam int TRI_W        = 6;

    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 144;

    localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

    localparam logic [CODE_W-1:0] CODE_A      = 3'd0;
    localparam logic [CODE_W-1:0] CODE_C      = 3'd1;
    localparam logic [CODE_W-1:0] CODE_G      = 3'd2;
    localparam logic [CODE_W-1:0] CODE_T      = 3'd3;
    localparam logic [CODE_W-1:0] CODE_MASKED = 3'd4;

    // packed lowest field last, so the word maps straight onto tdata
    typedef struct packed {
        logic [CNT_W-1:0]  base_count;
        logic [CNT_W-1:0]  trimer_pos;
        logic [TRI_W-1:0]  trimer_code;
        logic              trimer_valid;
        logic [CNT_W-1:0]  unmasked_total;
        logic              region_closes;
        logic              region_opens;
        logic [CODE_W-1:0] base_code;
        logic [CNT_W-1:0]  char_pos;
    } result_t;

    function automatic logic [CODE_W-1:0] classify(input logic [CHAR_W-1:0] ch);
        logic [CODE_W-1:0] code;
        case (ch)
            CHAR_A:  code = CODE_A;
            CHAR_C:  code = CODE_C;
            CHAR_G:  code = CODE_G;
            CHAR_T:  code = CODE_T;
            default: code = CODE_MASKED;
        endcase
        return code;
    endfunction

endpackage

[rtl/core/dri_tracker.sv]
// dri_tracker: running state of the indexer (position, counts, region flag,
// base history) and the combinational result for the word in the input stage
// depends on dri_pkg
module dri_tracker
    import dri_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [CHAR_W-1:0] base_char,
    input  logic              last_in_record,
    output result_t           res
);

    logic [POS_BITS-1:0] position_counter_reg;
    logic [POS_BITS-1:0] position_counter_next;
    logic [CNT_W-1:0]    unmasked_counter_reg;
    logic [CNT_W-1:0]    unmasked_counter_next;
    logic [CNT_W-1:0]    per_base_counts_reg [4];
    logic [CNT_W-1:0]    base_count_next;
    logic                region_open_reg;
    logic                region_open_next;
    logic [1:0]          prior_bases_reg [2];
    logic [1:0]          history_fill_reg;
    logic [1:0]          history_fill_next;

    logic [CODE_W-1:0]   code;
    logic                masked;
    logic [1:0]          idx;
    logic [CNT_W-1:0]    cur_count;
    logic [POS_BITS-1:0] tri_pos_full;
    logic [CNT_W-1:0]    pos_clip;
    logic [CNT_W-1:0]    tri_pos_clip;
    logic                tri_valid;

    assign code   = classify(base_char);
    assign masked = (code == CODE_MASKED);
    assign idx    = code[1:0];

    assign cur_count       = per_base_counts_reg[idx];
    assign base_count_next = (&cur_count) ? cur_count : cur_count + CNT_W'(1);
    assign unmasked_counter_next = (&unmasked_counter_reg) ? unmasked_counter_reg
                                                            : unmasked_counter_reg + CNT_W'(1);
    assign position_counter_next = (&position_counter_reg) ? position_counter_reg
                                                            : position_counter_reg + POS_BITS'(1);

    assign tri_valid    = !masked && (history_fill_reg == 2'd2);
    assign tri_pos_full = (position_counter_reg >= POS_BITS'(2))
                        ? position_counter_reg - POS_BITS'(2) : '0;

    // positions wider than the output field clip to all ones
    generate
        if (POS_BITS > CNT_W) begin : g_clip
            assign pos_clip     = (|position_counter_reg[POS_BITS-1:CNT_W])
                                ? '1 : position_counter_reg[CNT_W-1:0];
            assign tri_pos_clip = (|tri_pos_full[POS_BITS-1:CNT_W])
                                ? '1 : tri_pos_full[CNT_W-1:0];
        end else begin : g_ext
            assign pos_clip     = CNT_W'(position_counter_reg);
            assign tri_pos_clip = CNT_W'(tri_pos_full);
        end
    endgenerate

    always_comb
    begin
        region_open_next = region_open_reg;
        if (masked || last_in_record)
        begin
            region_open_next = 1'b0;
        end
        else
        begin
            region_open_next = 1'b1;
        end

        history_fill_next = history_fill_reg;
        if (masked || last_in_record)
        begin
            history_fill_next = 2'd0;
        end
        else if (history_fill_reg != 2'd2)
        begin
            history_fill_next = history_fill_reg + 2'd1;
        end
    end

    always_comb
    begin
        res.char_pos       = pos_clip;
        res.base_code      = code;
        res.region_opens   = !masked && !region_open_reg;
        res.region_closes  = masked ? region_open_reg : last_in_record;
        res.unmasked_total = masked ? unmasked_counter_reg : unmasked_counter_next;
        res.trimer_valid   = tri_valid;
        res.trimer_code    = tri_valid ? {prior_bases_reg[0], prior_bases_reg[1], idx} : '0;
        res.trimer_pos     = tri_valid ? tri_pos_clip : '0;
        res.base_count     = masked ? '0 : base_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_counter_reg   <= '0;
            unmasked_counter_reg   <= '0;
            per_base_counts_reg[0] <= '0;
            per_base_counts_reg[1] <= '0;
            per_base_counts_reg[2] <= '0;
            per_base_counts_reg[3] <= '0;
            region_open_reg        <= 1'b0;
            prior_bases_reg[0]     <= '0;
            prior_bases_reg[1]     <= '0;
            history_fill_reg       <= '0;
        end
        else if (step)
        begin
            position_counter_reg <= position_counter_next;
            region_open_reg      <= region_open_next;
            history_fill_reg     <= history_fill_next;
            if (!masked)
            begin
                unmasked_counter_reg     <= unmasked_counter_next;
                per_base_counts_reg[idx] <= base_count_next;
                prior_bases_reg[0]       <= prior_bases_reg[1];
                prior_bases_reg[1]       <= idx;
            end
        end
    end

    // a masked character or a record end leaves no open region and no history
    a_clear_after_break: assert property (@(posedge clk) disable iff (!rst_n)
        step && (masked || last_in_record) |=> history_fill_reg == 2'd0 && !region_open_reg)
        else $error("history or region survived a break");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        history_fill_reg != 2'd3)
        else $error("history fill out of range");

    // every per-base increment goes with an unmasked increment
    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        per_base_counts_reg[0] <= unmasked_counter_reg &&
        per_base_counts_reg[1] <= unmasked_counter_reg &&
        per_base_counts_reg[2] <= unmasked_counter_reg &&
        per_base_counts_reg[3] <= unmasked_counter_reg)
        else $error("per-base count exceeds unmasked total");

endmodule

[rtl/core/dna_region_trimer_indexer_core.sv]
// dna_region_trimer_indexer_core: top level, input stage, result register
// and stream handshake around the running-state tracker
// depends on dri_pkg and dri_tracker
//   slave side: one sequence character per word on s_tdata, with s_tlast high
//   on the last character of a record. every accepted word yields exactly one
//   result word on the master side, in order
//   master side: position, base code, region open/close flags, running
//   unmasked total, 3-mer code and start position, and per-base count
//   an accepted word is captured in the input stage and moves on into the
//   result register once that register is free or is being drained
//   throughput: one word per clock while m_tready stays high; the only
//   feedback path is the running state, which is updated in the same
//   cycle that the input stage hands its word on to the result register
//   stall: while m_tready is low the result holds, the input stage still
//   takes one more word, and s_tready then drops until the result is taken
//   reset: rst_n low clears both stages, all counters, the region flag and
//   the base history; no warm-up is needed afterwards
//   POS_BITS sets the width of the global position counter, which saturates
//   at its maximum; reported positions clip to all ones above 32 bits
module dna_region_trimer_indexer_core
    import dri_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    // slave side
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [7:0] base_char
    input  logic                s_tlast,   // last_in_record
    // master side
    output logic                m_tvalid,
    input  logic                m_tready,
    // [31:0] char_pos, [34:32] base_code, [35] region_opens,
    // [36] region_closes, [68:37] unmasked_total, [69] trimer_valid,
    // [75:70] trimer_code, [107:76] trimer_pos, [139:108] base_count,
    // [143:140] zero
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int RES_W = $bits(result_t);

    // input stage
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;

    // result register
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_data_reg;

    logic              advance;
    logic              s_accept;
    result_t           res;

    // the input stage moves on whenever the result register is empty or drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next  = s_accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    dri_tracker #(
        .POS_BITS (POS_BITS)
    ) u_tracker (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .base_char      (in_char_reg),
        .last_in_record (in_last_reg),
        .res            (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_char_reg <= s_tdata[CHAR_W-1:0];
            in_last_reg <= s_tlast;
        end
        if (advance)
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_DATA_W - RES_W)'(0), out_data_reg};

    // a held input word must never be overwritten
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |-> !s_tready)
        else $error("input stage overrun");

    // a masked result carries no count, no opening and no 3-mer
    a_masked_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.base_code == CODE_MASKED |->
        !out_data_reg.region_opens && !out_data_reg.trimer_valid &&
        out_data_reg.base_count == '0)
        else $error("masked result with base fields set");

    // a stalled result holds its value until it is taken
    a_result_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(out_data_reg))
        else $error("stalled result lost");

endmodule
